// ===== hw/rtl/ljv_pkg.sv =====
// Shared types, constants and saturating helpers for the Lennard-Jones step core
`timescale 1ns / 1ps
`default_nettype none

package ljv_pkg;

  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_STEP = 2'd1,
    REQ_READ = 2'd2
  } req_t;

  // rsq = sum of three squared 24-bit magnitudes stays below 2^50
  localparam int DM_W  = 24;
  localparam int RSQ_W = 50;
  // 2^64 / rsq needs 65 quotient bits (only rsq of one sets the top bit)
  localparam int QUO_W = 65;

  localparam logic [16:0] TIME_STEP_RST = 17'd655;
  localparam logic [7:0]  COUNT_RST     = 8'd125;

  // {clip, value}: clamp a wide signed sum to the 32-bit range
  function automatic logic [32:0] sat32(input logic signed [39:0] x);
    if (x > 40'sh007FFFFFFF) begin
      return {1'b1, 32'h7FFFFFFF};
    end else if (x < -40'sh0080000000) begin
      return {1'b1, 32'h80000000};
    end else begin
      return {1'b0, x[31:0]};
    end
  endfunction

  // unsigned 64-bit add that sticks at all ones
  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? {64{1'b1}} : s[63:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ljv_div.sv =====
// Bit-serial restoring divider computing 2^64 / rsq, saturated to 64 bits
`timescale 1ns / 1ps
`default_nettype none

module ljv_div import ljv_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RSQ_W-1:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [RSQ_W-1:0] rem_r;
  logic [RSQ_W-1:0] rem_nxt;
  logic [RSQ_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;
  logic [RSQ_W:0]   trial;
  logic [RSQ_W:0]   diff;
  logic             ge;

  // dividend is a one followed by 64 zeros
  assign trial   = {rem_r, (cnt_r == '0)};
  assign ge      = trial >= {1'b0, den_r};
  assign diff    = trial - {1'b0, den_r};
  assign rem_nxt = ge ? diff[RSQ_W-1:0] : trial[RSQ_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        den_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[QUO_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[QUO_W-1] ? {64{1'b1}} : quo_r[63:0];

endmodule

`default_nettype wire

// ===== hw/rtl/lennard_jones_verlet_step_core.sv =====
// Lennard-Jones velocity-Verlet step core: particle stores, sequencer and shared multiplier
`timescale 1ns / 1ps
`default_nettype none

// One word in, one word out for every request. Load and unknown requests put their
// result in the output register through the dispatch and emit states, reads through
// dispatch, read wait and emit; emit waits while the output register is held by out_stall.
// A step over n active particles visits n*(n-1)/2 pairs: each pair is dominated by the
// bit-serial reciprocal divider plus seven passes of the single 32x32 multiplier. A far
// pair skips both, a coincident pair skips the divider, and a product that saturates
// early ends its pass sooner. After reset a clearing pass over all MAX_PARTICLES entries
// zeroes velocities and accelerations; in_stall stays high during it, configuration
// writes are taken as usual.
module lennard_jones_verlet_step_core import ljv_pkg::*; #(
  parameter int MAX_PARTICLES = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic [6:0]         in_particle_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_index,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               out_saturated
);

  localparam int IW = $clog2(MAX_PARTICLES);
  localparam int CW = $clog2(MAX_PARTICLES + 1);

  localparam logic REG_TIME_STEP      = 1'b0;
  localparam logic REG_PARTICLE_COUNT = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_READ_WAIT, ST_EMIT,
    ST_K_RD, ST_K_LAT, ST_K_MUL, ST_K_ADD, ST_K_WR,
    ST_PI_RD, ST_PI_LAT, ST_PJ_RD, ST_PJ_LAT,
    ST_RSQ_MUL, ST_RSQ_ADD, ST_DIV_GO, ST_DIV_WAIT,
    ST_QMUL, ST_QNEXT, ST_T, ST_MAG, ST_M24, ST_ACC,
    ST_PJ_WR, ST_PI_WR
  } st_t;

  typedef enum logic [2:0] {QS_Q2, QS_Q4, QS_Q6, QS_Q7, QS_CX} qsel_t;

  typedef logic [2:0][31:0] vec_t;

  // configuration
  logic [16:0] time_step_r;
  logic [7:0]  count_r;
  logic        cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= TIME_STEP_RST;
      count_r     <= COUNT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TIME_STEP:      time_step_r <= pwdata[16:0];
        REG_PARTICLE_COUNT: count_r     <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TIME_STEP:      prdata = {15'd0, time_step_r};
      REG_PARTICLE_COUNT: prdata = {24'd0, count_r};
    endcase
  end

  // particle stores
  vec_t pos_mem [MAX_PARTICLES];
  vec_t vel_mem [MAX_PARTICLES];
  vec_t acc_mem [MAX_PARTICLES];

  logic          pos_we, vel_we, acc_we;
  logic [IW-1:0] wr_addr, rd_addr;
  vec_t          pos_wd, vel_wd, acc_wd;
  vec_t          pos_rd_r, vel_rd_r, acc_rd_r;

  always_ff @(posedge clk) begin
    if (pos_we) pos_mem[wr_addr] <= pos_wd;
    if (vel_we) vel_mem[wr_addr] <= vel_wd;
    if (acc_we) acc_mem[wr_addr] <= acc_wd;
    pos_rd_r <= pos_mem[rd_addr];
    vel_rd_r <= vel_mem[rd_addr];
    acc_rd_r <= acc_mem[rd_addr];
  end

  // sequencer registers
  st_t              state_r;
  qsel_t            qsel_r;
  logic [2:0]       qs_r;
  logic [1:0]       k_r;
  logic             drift_r;
  logic             pass2_r;
  logic             sat_r;
  logic [CW-1:0]    i_r, j_r, n_r;
  logic [1:0]       req_r;
  logic [6:0]       idx_r;
  vec_t             ld_r;
  vec_t             wp_r, wv_r, wa_r, aj_r;
  logic [2:0][DM_W-1:0] dm_r;
  logic [2:0]       dneg_r;
  logic [RSQ_W-1:0] rsq_r;
  logic [63:0]      q_r, q2_r, q4_r, q7_r, t_r, mag_r, qa_r, qb_r, qacc_r;
  logic             fneg_r;
  logic [63:0]      prod_r;

  logic             out_valid_r;
  logic [6:0]       out_index_r, res_index_r;
  vec_t             out_pos_r, res_pos_r;
  logic             out_sat_r, res_sat_r;

  logic             idx_ok;
  logic [IW-1:0]    idx_addr;

  assign idx_ok   = 32'(idx_r) < 32'(MAX_PARTICLES);
  assign idx_addr = IW'(idx_r);

  // shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [31:0] kd_src, kd_abs;

  assign kd_src = drift_r ? wv_r[k_r] : wa_r[k_r];
  assign kd_abs = kd_src[31] ? (32'd0 - kd_src) : kd_src;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_K_MUL: begin
        mul_a = kd_abs;
        mul_b = {15'd0, time_step_r};
      end
      ST_RSQ_MUL: begin
        mul_a = {8'd0, dm_r[k_r]};
        mul_b = {8'd0, dm_r[k_r]};
      end
      ST_QMUL: begin
        unique case (qs_r)
          3'd0: begin
            mul_a = qa_r[63:32];
            mul_b = qb_r[63:32];
          end
          3'd1: begin
            mul_a = qa_r[63:32];
            mul_b = qb_r[31:0];
          end
          3'd2: begin
            mul_a = qa_r[31:0];
            mul_b = qb_r[63:32];
          end
          default: begin
            mul_a = qa_r[31:0];
            mul_b = qb_r[31:0];
          end
        endcase
      end
      default: ;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
  end

  // kick / drift update: v += a*dt >> 17, r += v*dt >> 16, truncated toward zero
  logic [31:0] k_tgt;
  logic [32:0] k_mag;
  logic [39:0] k_sum;
  logic [32:0] k_sat;

  assign k_tgt = drift_r ? wp_r[k_r] : wv_r[k_r];
  assign k_mag = drift_r ? prod_r[48:16] : {1'b0, prod_r[48:17]};
  assign k_sum = {{8{k_tgt[31]}}, k_tgt} +
                 (kd_src[31] ? (40'd0 - {7'd0, k_mag}) : {7'd0, k_mag});
  assign k_sat = sat32(k_sum);

  // pair separation and far-pair test
  logic [2:0][32:0] d_w;
  logic [2:0][32:0] d_abs;
  logic             far;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_w[a]   = {wp_r[a][31], wp_r[a]} - {pos_rd_r[a][31], pos_rd_r[a]};
      d_abs[a] = d_w[a][32] ? (33'd0 - d_w[a]) : d_w[a];
    end
    far = (d_abs[0][32:DM_W] != '0) || (d_abs[1][32:DM_W] != '0) ||
          (d_abs[2][32:DM_W] != '0);
  end

  // force magnitude pieces
  logic        fneg_w;
  logic [63:0] diff_w;
  logic [68:0] m24_w;
  logic [63:0] m24;

  assign fneg_w = t_r < q4_r;
  assign diff_w = fneg_w ? (q4_r - t_r) : (t_r - q4_r);
  assign m24_w  = {1'b0, mag_r, 4'd0} + {2'd0, mag_r, 3'd0};
  assign m24    = (m24_w[68:64] != '0) ? {64{1'b1}} : m24_w[63:0];

  // per-axis contribution and accumulation
  logic        c_neg, c_clip;
  logic [31:0] cv;
  logic [32:0] ai_sat, aj_sat;

  always_comb begin
    c_neg = dneg_r[k_r] ^ fneg_r;
    if (c_neg) begin
      c_clip = qacc_r > 64'h0000_0000_8000_0000;
      cv     = c_clip ? 32'h8000_0000 : (32'd0 - qacc_r[31:0]);
    end else begin
      c_clip = qacc_r > 64'h0000_0000_7FFF_FFFF;
      cv     = c_clip ? 32'h7FFF_FFFF : qacc_r[31:0];
    end
    ai_sat = sat32({{8{wa_r[k_r][31]}}, wa_r[k_r]} + {{8{cv[31]}}, cv});
    aj_sat = sat32({{8{aj_r[k_r][31]}}, aj_r[k_r]} - {{8{cv[31]}}, cv});
  end

  // reciprocal divider
  logic        div_start, div_done;
  logic [63:0] div_q;

  assign div_start = (state_r == ST_DIV_GO) && (rsq_r != '0);

  ljv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (rsq_r),
    .done     (div_done),
    .quotient (div_q)
  );

  // memory port control
  always_comb begin
    pos_we  = 1'b0;
    vel_we  = 1'b0;
    acc_we  = 1'b0;
    wr_addr = i_r[IW-1:0];
    rd_addr = i_r[IW-1:0];
    pos_wd  = wp_r;
    vel_wd  = '0;
    acc_wd  = '0;
    unique case (state_r)
      ST_CLEAR: begin
        vel_we = 1'b1;
        acc_we = 1'b1;
      end
      ST_DISPATCH: begin
        wr_addr = idx_addr;
        rd_addr = idx_addr;
        pos_wd  = ld_r;
        if (req_r == REQ_LOAD && idx_ok) begin
          pos_we = 1'b1;
          vel_we = 1'b1;
          acc_we = 1'b1;
        end
      end
      ST_K_WR: begin
        vel_we = 1'b1;
        vel_wd = wv_r;
        if (!pass2_r) begin
          pos_we = 1'b1;
          acc_we = 1'b1;
        end
      end
      ST_PJ_RD: rd_addr = j_r[IW-1:0];
      ST_PJ_WR: begin
        wr_addr = j_r[IW-1:0];
        acc_we  = 1'b1;
        acc_wd  = aj_r;
      end
      ST_PI_WR: begin
        acc_we = 1'b1;
        acc_wd = wa_r;
      end
      default: ;
    endcase
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      i_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          if (i_r == CW'(MAX_PARTICLES - 1)) begin
            i_r     <= '0;
            state_r <= ST_IDLE;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            req_r   <= in_req_type;
            idx_r   <= in_particle_index;
            ld_r    <= {in_pos_z, in_pos_y, in_pos_x};
            state_r <= ST_DISPATCH;
          end
        end
        ST_DISPATCH: begin
          res_pos_r <= '0;
          res_sat_r <= 1'b0;
          unique case (req_r)
            REQ_LOAD: begin
              res_index_r <= idx_r;
              state_r     <= ST_EMIT;
            end
            REQ_STEP: begin
              res_index_r <= '0;
              sat_r       <= 1'b0;
              n_r         <= (32'(count_r) > 32'(MAX_PARTICLES)) ?
                             CW'(MAX_PARTICLES) : CW'(count_r);
              i_r         <= '0;
              pass2_r     <= 1'b0;
              state_r     <= ST_K_RD;
            end
            REQ_READ: begin
              res_index_r <= idx_r;
              state_r     <= ST_READ_WAIT;
            end
            default: begin
              res_index_r <= '0;
              state_r     <= ST_EMIT;
            end
          endcase
        end
        ST_READ_WAIT: begin
          res_pos_r <= idx_ok ? pos_rd_r : '0;
          state_r   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_index_r <= res_index_r;
            out_pos_r   <= res_pos_r;
            out_sat_r   <= res_sat_r;
            state_r     <= ST_IDLE;
          end
        end
        // kick (and drift on the first pass), one particle at a time
        ST_K_RD: begin
          if (i_r == n_r) begin
            if (pass2_r) begin
              res_sat_r <= sat_r;
              state_r   <= ST_EMIT;
            end else begin
              i_r     <= '0;
              state_r <= ST_PI_RD;
            end
          end else begin
            state_r <= ST_K_LAT;
          end
        end
        ST_K_LAT: begin
          wp_r    <= pos_rd_r;
          wv_r    <= vel_rd_r;
          wa_r    <= acc_rd_r;
          k_r     <= '0;
          drift_r <= 1'b0;
          state_r <= ST_K_MUL;
        end
        ST_K_MUL: state_r <= ST_K_ADD;
        ST_K_ADD: begin
          if (drift_r) wp_r[k_r] <= k_sat[31:0];
          else         wv_r[k_r] <= k_sat[31:0];
          if (k_sat[32]) sat_r <= 1'b1;
          if (k_r == 2'd2) begin
            k_r <= '0;
            if (!drift_r && !pass2_r) begin
              drift_r <= 1'b1;
              state_r <= ST_K_MUL;
            end else begin
              state_r <= ST_K_WR;
            end
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_K_MUL;
          end
        end
        ST_K_WR: begin
          i_r     <= i_r + 1'b1;
          state_r <= ST_K_RD;
        end
        // pair loop; acceleration of i is held in wa_r across its j sweep
        ST_PI_RD: begin
          if (({1'b0, i_r} + 1'b1) >= {1'b0, n_r}) begin
            i_r     <= '0;
            pass2_r <= 1'b1;
            state_r <= ST_K_RD;
          end else begin
            state_r <= ST_PI_LAT;
          end
        end
        ST_PI_LAT: begin
          wp_r    <= pos_rd_r;
          wa_r    <= acc_rd_r;
          j_r     <= i_r + 1'b1;
          state_r <= ST_PJ_RD;
        end
        ST_PJ_RD: begin
          state_r <= (j_r == n_r) ? ST_PI_WR : ST_PJ_LAT;
        end
        ST_PJ_LAT: begin
          aj_r <= acc_rd_r;
          for (int a = 0; a < 3; a++) begin
            dm_r[a]   <= d_abs[a][DM_W-1:0];
            dneg_r[a] <= d_w[a][32];
          end
          if (far) begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_PJ_RD;
          end else begin
            k_r     <= '0;
            rsq_r   <= '0;
            state_r <= ST_RSQ_MUL;
          end
        end
        ST_RSQ_MUL: state_r <= ST_RSQ_ADD;
        ST_RSQ_ADD: begin
          rsq_r <= rsq_r + prod_r[RSQ_W-1:0];
          if (k_r == 2'd2) begin
            k_r     <= '0;
            state_r <= ST_DIV_GO;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_RSQ_MUL;
          end
        end
        ST_DIV_GO: begin
          if (rsq_r == '0) begin
            // coincident particles
            sat_r   <= 1'b1;
            j_r     <= j_r + 1'b1;
            state_r <= ST_PJ_RD;
          end else begin
            state_r <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            q_r     <= div_q;
            qa_r    <= div_q;
            qb_r    <= div_q;
            qsel_r  <= QS_Q2;
            qs_r    <= '0;
            state_r <= ST_QMUL;
          end
        end
        // (qa*qb) >> 32 saturated, one partial product per cycle
        ST_QMUL: begin
          unique case (qs_r)
            3'd0: qs_r <= 3'd1;
            3'd1: begin
              if (prod_r[63:32] != '0) begin
                qacc_r  <= {64{1'b1}};
                state_r <= ST_QNEXT;
              end else begin
                qacc_r <= {prod_r[31:0], 32'd0};
                qs_r   <= 3'd2;
              end
            end
            3'd2: begin
              qacc_r <= sadd64(qacc_r, prod_r);
              qs_r   <= 3'd3;
            end
            3'd3: begin
              qacc_r <= sadd64(qacc_r, prod_r);
              qs_r   <= 3'd4;
            end
            default: begin
              qacc_r  <= sadd64(qacc_r, {32'd0, prod_r[63:32]});
              state_r <= ST_QNEXT;
            end
          endcase
        end
        ST_QNEXT: begin
          qs_r <= '0;
          unique case (qsel_r)
            QS_Q2: begin
              q2_r    <= qacc_r;
              qa_r    <= qacc_r;
              qb_r    <= qacc_r;
              qsel_r  <= QS_Q4;
              state_r <= ST_QMUL;
            end
            QS_Q4: begin
              q4_r    <= qacc_r;
              qa_r    <= qacc_r;
              qb_r    <= q2_r;
              qsel_r  <= QS_Q6;
              state_r <= ST_QMUL;
            end
            QS_Q6: begin
              qa_r    <= qacc_r;
              qb_r    <= q_r;
              qsel_r  <= QS_Q7;
              state_r <= ST_QMUL;
            end
            QS_Q7: begin
              q7_r    <= qacc_r;
              state_r <= ST_T;
            end
            QS_CX: state_r <= ST_ACC;
            default: state_r <= ST_ACC;
          endcase
        end
        ST_T: begin
          t_r     <= sadd64(q7_r, q7_r);
          state_r <= ST_MAG;
        end
        ST_MAG: begin
          fneg_r  <= fneg_w;
          mag_r   <= diff_w;
          state_r <= ST_M24;
        end
        ST_M24: begin
          mag_r   <= m24;
          qa_r    <= {40'd0, dm_r[0]};
          qb_r    <= m24;
          k_r     <= '0;
          qsel_r  <= QS_CX;
          state_r <= ST_QMUL;
        end
        ST_ACC: begin
          wa_r[k_r] <= ai_sat[31:0];
          aj_r[k_r] <= aj_sat[31:0];
          if (ai_sat[32] || aj_sat[32] || c_clip) sat_r <= 1'b1;
          if (k_r == 2'd2) begin
            state_r <= ST_PJ_WR;
          end else begin
            k_r     <= k_r + 1'b1;
            qa_r    <= {40'd0, dm_r[k_r + 2'd1]};
            qb_r    <= mag_r;
            state_r <= ST_QMUL;
          end
        end
        ST_PJ_WR: begin
          j_r     <= j_r + 1'b1;
          state_r <= ST_PJ_RD;
        end
        ST_PI_WR: begin
          i_r     <= i_r + 1'b1;
          state_r <= ST_PI_RD;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_index     = out_index_r;
  assign out_x         = out_pos_r[0];
  assign out_y         = out_pos_r[1];
  assign out_z         = out_pos_r[2];
  assign out_saturated = out_sat_r;

endmodule

`default_nettype wire

// ===== hw/rtl/ljv_checker.sv =====
// Port-level checks for the Lennard-Jones step core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ljv_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [6:0]  out_index,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        out_saturated
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index) && $stable(out_x) &&
      $stable(out_saturated))
    else $error("stalled output word changed");

  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during reset clearing");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in flight");

  a_flag_only_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_index == 7'd0 && out_x == 32'd0 &&
      out_y == 32'd0 && out_z == 32'd0)
    else $error("saturation flag on a non-step result");

endmodule

bind lennard_jones_verlet_step_core ljv_props u_ljv_props (.*);

`default_nettype wire
